FILE: sv/wcsg_pkg.sv
package wcsg_pkg;

	// Buffer capacities and the cap on segments per circle.
	localparam int MAX_VERTICES = 4096;
	localparam int MAX_INDICES  = 4096;
	localparam int MAX_SEGMENTS = 16;
	localparam int PLANE_CAP    = 16;
	localparam int D_CAP        = (MAX_SEGMENTS < PLANE_CAP) ? MAX_SEGMENTS : PLANE_CAP;
	localparam int CNT_W        = 13;

	// Q2.30 constants.
	localparam logic signed [31:0] ONE_Q30       = 32'sd1073741824;
	localparam logic signed [31:0] NEAR_POLE_Q30 = 32'sd1063004406;

	// Request kinds.
	localparam logic [1:0] KIND_BEGIN  = 2'd0;
	localparam logic [1:0] KIND_CIRCLE = 2'd1;
	localparam logic [1:0] KIND_SPHERE = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_DIV_INIT, S_DIV, S_TAN,
		S_B_MUL1, S_B_MUL2, S_B_WB, S_CIR_START, S_TRIG_INIT, S_TRIG_Z2, S_H_MUL,
		S_H_WB, S_F_MUL, S_F_WB, S_P_MUL1, S_P_MUL2, S_P_W, S_P_MUL3, S_P_WB,
		S_PT_FIRST, S_EMIT
	} state_t;

	typedef enum logic [4:0] {
		C_NONE, C_LOAD, C_CLEAR, C_NORM_START, C_PLANE_SET, C_SQ_MUL, C_SQ_ACC,
		C_SQRT_STEP, C_DIV_INIT, C_DIV_STEP, C_TAN_START, C_B_MUL1, C_B_MUL2, C_B_WB,
		C_CIR_START, C_TRIG_INIT, C_TRIG_Z2, C_H_MUL, C_H_WB, C_F_MUL, C_F_WB,
		C_P_MUL1, C_P_MUL2, C_P_W, C_P_MUL3, C_P_WB, C_PT_FIRST, C_EMIT
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       r_pos;
		logic       d_zero;
		logic       k_last;
		logic       it_zero;
		logic       dest_t;
		logic       h_zero;
		logic       trig_sin;
		logic       first;
		logic       seg_last;
		logic       plane_more;
		logic       out_free;
	} status_t;

	// Taylor coefficients of the quarter-wave sine, Q30.
	function automatic logic [31:0] sine_coef(input logic [2:0] h);
		case (h)
			3'd0: sine_coef = 32'd1686629713;
			3'd1: sine_coef = 32'd693598668;
			3'd2: sine_coef = 32'd85569306;
			3'd3: sine_coef = 32'd5026994;
			3'd4: sine_coef = 32'd172272;
			3'd5: sine_coef = 32'd3864;
			default: sine_coef = 32'd0;
		endcase
	endfunction

	// Quotient of 2^32 by the segment count.
	function automatic logic [32:0] step_quot(input logic [4:0] d);
		case (d)
			5'd1:  step_quot = 33'd4294967296;
			5'd2:  step_quot = 33'd2147483648;
			5'd3:  step_quot = 33'd1431655765;
			5'd4:  step_quot = 33'd1073741824;
			5'd5:  step_quot = 33'd858993459;
			5'd6:  step_quot = 33'd715827882;
			5'd7:  step_quot = 33'd613566756;
			5'd8:  step_quot = 33'd536870912;
			5'd9:  step_quot = 33'd477218588;
			5'd10: step_quot = 33'd429496729;
			5'd11: step_quot = 33'd390451572;
			5'd12: step_quot = 33'd357913941;
			5'd13: step_quot = 33'd330382099;
			5'd14: step_quot = 33'd306783378;
			5'd15: step_quot = 33'd286331153;
			5'd16: step_quot = 33'd268435456;
			default: step_quot = 33'd0;
		endcase
	endfunction

	// Remainder of 2^32 by the segment count.
	function automatic logic [4:0] step_rem(input logic [4:0] d);
		case (d)
			5'd3, 5'd5, 5'd15: step_rem = 5'd1;
			5'd6, 5'd7, 5'd9, 5'd11, 5'd12, 5'd14: step_rem = 5'd4;
			5'd10: step_rem = 5'd6;
			5'd13: step_rem = 5'd9;
			default: step_rem = 5'd0;
		endcase
	endfunction

endpackage

FILE: sv/wire_circle_segment_generator.sv
// Wire circle segment generator.
// A request on the s_axis channel either begins a frame (kind 0, clears the vertex and
// index counters), tessellates one oriented circle (kind 1) or a wire sphere of three
// axis-plane circles (kind 2). Each circle of d segments yields d results on m_axis, one
// per line segment; tlast marks the final segment of a request and tuser carries kept.
// Requests are taken one at a time: s_axis_tready is high only while the controller idles.
// An oriented circle first normalizes the normal and then the tangent; each normalization
// takes three squares, a 32-step square root and three 31-step divisions, and the basis is
// completed by the binormal, their cross product. Every circle point is then worked out on
// the one shared multiplier (cosine and sine by Horner steps, then three coordinates). A
// begin frame or a request that yields nothing goes back to idle from the decode state.
// The last result waits in an output register; the next request is accepted while it is
// held. When the receiver stalls, the generator pauses before each further segment.
// Reset clears the controller, the counters and the output valid.
module wire_circle_segment_generator import wcsg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// center_x, center_y, center_z, radius, normal_x, normal_y, normal_z, line_color,
	// segment_count, zero fill
	input  logic [263:0] s_axis_tdata,
	// kind
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, segment_color, vertex_slot, zero fill
	output logic [239:0] m_axis_tdata,
	// kept
	output logic         m_axis_tuser,
	// last_segment
	output logic         m_axis_tlast
);

	cmd_t    cmd;
	status_t st;

	wcsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	wcsg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_kind   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kept  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

FILE: sv/wcsg_ctrl.sv
module wcsg_ctrl import wcsg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command.
	always_comb begin
		state_d  = state_q;
		cmd      = C_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = C_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				if (st.kind == KIND_BEGIN) begin
					cmd = C_CLEAR;
				end else if (st.kind == KIND_CIRCLE) begin
					if (st.r_pos && !st.d_zero) begin
						cmd     = C_NORM_START;
						state_d = S_SQ_MUL;
					end
				end else if (st.kind == KIND_SPHERE) begin
					if (!st.d_zero) begin
						cmd     = C_PLANE_SET;
						state_d = S_CIR_START;
					end
				end
			end
			S_SQ_MUL: begin
				cmd     = C_SQ_MUL;
				state_d = S_SQ_ACC;
			end
			S_SQ_ACC: begin
				cmd     = C_SQ_ACC;
				state_d = st.k_last ? S_SQRT : S_SQ_MUL;
			end
			S_SQRT: begin
				cmd = C_SQRT_STEP;
				if (st.it_zero) state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd     = C_DIV_INIT;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd = C_DIV_STEP;
				if (st.it_zero) begin
					if (!st.k_last) state_d = S_DIV_INIT;
					else state_d = st.dest_t ? S_B_MUL1 : S_TAN;
				end
			end
			S_TAN: begin
				cmd     = C_TAN_START;
				state_d = S_SQ_MUL;
			end
			S_B_MUL1: begin
				cmd     = C_B_MUL1;
				state_d = S_B_MUL2;
			end
			S_B_MUL2: begin
				cmd     = C_B_MUL2;
				state_d = S_B_WB;
			end
			S_B_WB: begin
				cmd     = C_B_WB;
				state_d = st.k_last ? S_CIR_START : S_B_MUL1;
			end
			S_CIR_START: begin
				cmd     = C_CIR_START;
				state_d = S_TRIG_INIT;
			end
			S_TRIG_INIT: begin
				cmd     = C_TRIG_INIT;
				state_d = S_TRIG_Z2;
			end
			S_TRIG_Z2: begin
				cmd     = C_TRIG_Z2;
				state_d = S_H_MUL;
			end
			S_H_MUL: begin
				cmd     = C_H_MUL;
				state_d = S_H_WB;
			end
			S_H_WB: begin
				cmd     = C_H_WB;
				state_d = st.h_zero ? S_F_MUL : S_H_MUL;
			end
			S_F_MUL: begin
				cmd     = C_F_MUL;
				state_d = S_F_WB;
			end
			S_F_WB: begin
				cmd     = C_F_WB;
				state_d = st.trig_sin ? S_P_MUL1 : S_TRIG_INIT;
			end
			S_P_MUL1: begin
				cmd     = C_P_MUL1;
				state_d = S_P_MUL2;
			end
			S_P_MUL2: begin
				cmd     = C_P_MUL2;
				state_d = S_P_W;
			end
			S_P_W: begin
				cmd     = C_P_W;
				state_d = S_P_MUL3;
			end
			S_P_MUL3: begin
				cmd     = C_P_MUL3;
				state_d = S_P_WB;
			end
			S_P_WB: begin
				cmd = C_P_WB;
				if (st.k_last) state_d = st.first ? S_PT_FIRST : S_EMIT;
				else state_d = S_P_MUL1;
			end
			S_PT_FIRST: begin
				cmd     = C_PT_FIRST;
				state_d = S_TRIG_INIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd = C_EMIT;
					if (!st.seg_last) state_d = S_TRIG_INIT;
					else if (st.plane_more) state_d = S_CIR_START;
					else state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/wcsg_datapath.sv
module wcsg_datapath import wcsg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output status_t      st,
	input  logic [1:0]   in_kind,
	input  logic [263:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [239:0] out_data,
	output logic         out_kept,
	output logic         out_last
);

	// Request registers.
	logic [1:0]         kind_q;
	logic signed [31:0] ctr_q [3];
	logic signed [31:0] r_q;
	logic [31:0]        color_q;
	logic [4:0]         d_q;

	// Frame basis and normalization registers.
	logic signed [32:0] vec_q [3];
	logic signed [31:0] n_q [3];
	logic signed [31:0] t_q [3];
	logic signed [31:0] b_q [3];
	logic               dest_t_q;
	logic [1:0]         k_q;
	logic [4:0]         it_q;
	logic [63:0]        sum_q;
	logic [63:0]        x_q;
	logic [63:0]        rt_q;
	logic [31:0]        len_q;
	logic [32:0]        rem_q;
	logic [30:0]        quo_q;

	// Shared multiplier and accumulator.
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	logic signed [63:0] acc_q;

	// Sine evaluation and point registers.
	logic [30:0]        z_q, z2_q;
	logic [31:0]        hr_q;
	logic [2:0]         h_q;
	logic               neg_q, trig_q;
	logic signed [31:0] cosv_q, sinv_q;
	logic signed [32:0] w_q;
	logic [32:0]        pq_q;
	logic [4:0]         prem_q;
	logic [3:0]         seg_q;
	logic [1:0]         plane_q;
	logic               first_q;
	logic signed [31:0] start_q [3];
	logic signed [31:0] end_q [3];
	logic [CNT_W-1:0]   vc_q, ic_q;

	// Result register.
	logic               out_valid_q;
	logic signed [31:0] o_start_q [3];
	logic signed [31:0] o_end_q [3];
	logic [31:0]        o_color_q;
	logic [11:0]        o_slot_q;
	logic               o_kept_q, o_last_q;

	function automatic logic [1:0] nxt3(input logic [1:0] k);
		nxt3 = (k == 2'd2) ? 2'd0 : k + 2'd1;
	endfunction

	logic [1:0]  k1, k2, k_n;
	logic [31:0] mag_k;
	logic [31:0] ph, arg;
	logic [30:0] z_c;
	logic [63:0] bb, rb, rt_n;
	logic        sq_ge;
	logic [33:0] rem2;
	logic        d_ge, d_ge0;
	logic [30:0] quo_n;
	logic [32:0] rem_n;
	logic [30:0] qv;
	logic signed [31:0] qs;
	logic [63:0] sum_n;
	logic [31:0] hsub;
	logic [32:0] fm;
	logic [30:0] fcap;
	logic signed [31:0] fval;
	logic signed [63:0] bdiff, psum;
	logic signed [36:0] pv;
	logic signed [31:0] psat;
	logic [4:0]  rs;
	logic        pwrap;
	logic [32:0] pq_n;
	logic [4:0]  prem_n;
	logic        kept_c;
	logic        plane_adv;
	logic [1:0]  plane_n;

	// Index helpers, square root step, division step and phase step.
	always_comb begin
		k1     = nxt3(k_q);
		k2     = nxt3(k1);
		k_n    = k1;
		mag_k  = vec_q[k_q][32] ? 32'(-vec_q[k_q]) : vec_q[k_q][31:0];
		ph     = pq_q[31:0];
		arg    = trig_q ? ph : ph + 32'h4000_0000;
		z_c    = arg[30] ? (31'h4000_0000 - {1'b0, arg[29:0]}) : {1'b0, arg[29:0]};
		bb     = 64'd1 << {it_q, 1'b0};
		rb     = rt_q + bb;
		sq_ge  = x_q >= rb;
		rt_n   = sq_ge ? (rt_q >> 1) + bb : (rt_q >> 1);
		rem2   = {rem_q, 1'b0};
		d_ge   = rem2 >= {2'b00, len_q};
		quo_n  = {quo_q[29:0], d_ge};
		rem_n  = d_ge ? 33'(rem2 - {2'b00, len_q}) : rem2[32:0];
		d_ge0  = mag_k >= len_q;
		qv     = (len_q == 32'd0) ? 31'd0 : quo_n;
		qs     = vec_q[k_q][32] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
		sum_n  = sum_q + 64'(prod_q);
		hsub   = sine_coef(h_q) - prod_q[61:30];
		fm     = prod_q[62:30];
		fcap   = (fm > 33'h4000_0000) ? 31'h4000_0000 : fm[30:0];
		fval   = neg_q ? -$signed({1'b0, fcap}) : $signed({1'b0, fcap});
		bdiff  = acc_q - 64'(prod_q);
		psum   = acc_q + 64'(prod_q);
		pv     = 37'(ctr_q[k_q]) + 37'($signed(prod_q[65:30]));
		if (pv > 37'sd2147483647) psat = 32'sh7FFF_FFFF;
		else if (pv < -37'sd2147483648) psat = 32'sh8000_0000;
		else psat = pv[31:0];
		rs     = prem_q + step_rem(d_q);
		pwrap  = rs >= d_q;
		pq_n   = pq_q + step_quot(d_q) + 33'(pwrap);
		prem_n = pwrap ? rs - d_q : rs;
		kept_c = !(({1'b0, vc_q} + 14'd2 >= 14'(MAX_VERTICES)) ||
		           ({1'b0, ic_q} + 14'd2 >= 14'(MAX_INDICES)));
		plane_adv = st.seg_last && st.plane_more;
		plane_n   = (cmd == C_EMIT && plane_adv) ? plane_q + 2'd1 : 2'd0;
	end

	// Multiplier operand selection.
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd)
			C_SQ_MUL: begin
				ma = $signed({1'b0, mag_k});
				mb = $signed({1'b0, mag_k});
			end
			C_TRIG_INIT: begin
				ma = $signed({2'b00, z_c});
				mb = $signed({2'b00, z_c});
			end
			C_H_MUL: begin
				ma = $signed({2'b00, z2_q});
				mb = $signed({1'b0, hr_q});
			end
			C_F_MUL: begin
				ma = $signed({2'b00, z_q});
				mb = $signed({1'b0, hr_q});
			end
			C_B_MUL1: begin
				ma = 33'(n_q[k1]);
				mb = 33'(t_q[k2]);
			end
			C_B_MUL2: begin
				ma = 33'(n_q[k2]);
				mb = 33'(t_q[k1]);
			end
			C_P_MUL1: begin
				ma = 33'(t_q[k_q]);
				mb = 33'(cosv_q);
			end
			C_P_MUL2: begin
				ma = 33'(b_q[k_q]);
				mb = 33'(sinv_q);
			end
			C_P_MUL3: begin
				ma = w_q;
				mb = 33'(r_q);
			end
			default: ;
		endcase
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (cmd)
			C_LOAD: begin
				kind_q   <= in_kind;
				ctr_q[0] <= in_data[31:0];
				ctr_q[1] <= in_data[63:32];
				ctr_q[2] <= in_data[95:64];
				r_q      <= in_data[127:96];
				vec_q[0] <= 33'($signed(in_data[159:128]));
				vec_q[1] <= 33'($signed(in_data[191:160]));
				vec_q[2] <= 33'($signed(in_data[223:192]));
				color_q  <= in_data[255:224];
				d_q      <= (in_data[260:256] > 5'(D_CAP)) ? 5'(D_CAP) : in_data[260:256];
			end
			C_NORM_START: begin
				sum_q    <= '0;
				k_q      <= 2'd0;
				dest_t_q <= 1'b0;
			end
			C_TAN_START: begin
				// Tangent seed is the normal crossed with the Y axis, or the X axis near the pole.
				if ($signed(n_q[1][31] ? -n_q[1] : n_q[1]) < NEAR_POLE_Q30) begin
					vec_q[0] <= -33'(n_q[2]);
					vec_q[1] <= '0;
					vec_q[2] <= 33'(n_q[0]);
				end else begin
					vec_q[0] <= '0;
					vec_q[1] <= 33'(n_q[2]);
					vec_q[2] <= -33'(n_q[1]);
				end
				sum_q    <= '0;
				k_q      <= 2'd0;
				dest_t_q <= 1'b1;
			end
			C_PLANE_SET, C_EMIT: begin
				if (cmd == C_PLANE_SET || plane_adv) begin
					plane_q <= plane_n;
					for (int j = 0; j < 3; j++) begin
						t_q[j] <= (2'(j) == plane_n) ? ONE_Q30 : 32'sd0;
						b_q[j] <= (2'(j) == nxt3(plane_n)) ? ONE_Q30 : 32'sd0;
					end
				end
				if (cmd == C_EMIT) begin
					o_start_q <= start_q;
					o_end_q   <= end_q;
					o_color_q <= color_q;
					o_slot_q  <= kept_c ? vc_q[11:0] : 12'd0;
					o_kept_q  <= kept_c;
					o_last_q  <= st.seg_last && !st.plane_more;
					start_q   <= end_q;
					seg_q     <= seg_q + 4'd1;
					pq_q      <= pq_n;
					prem_q    <= prem_n;
				end
			end
			C_SQ_ACC: begin
				sum_q <= sum_n;
				k_q   <= k_n;
				if (st.k_last) begin
					x_q  <= sum_n;
					rt_q <= '0;
					it_q <= 5'd31;
				end
			end
			C_SQRT_STEP: begin
				if (sq_ge) x_q <= x_q - rb;
				rt_q <= rt_n;
				it_q <= it_q - 5'd1;
				if (st.it_zero) len_q <= rt_n[31:0];
			end
			C_DIV_INIT: begin
				rem_q <= d_ge0 ? {1'b0, mag_k - len_q} : {1'b0, mag_k};
				quo_q <= {30'd0, d_ge0};
				it_q  <= 5'd29;
			end
			C_DIV_STEP: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				it_q  <= it_q - 5'd1;
				if (st.it_zero) begin
					if (dest_t_q) t_q[k_q] <= qs;
					else n_q[k_q] <= qs;
					k_q <= k_n;
				end
			end
			C_B_MUL2, C_P_MUL2: begin
				acc_q <= 64'(prod_q);
			end
			C_B_WB: begin
				b_q[k_q] <= bdiff[61:30];
				k_q      <= k_n;
			end
			C_CIR_START: begin
				pq_q    <= '0;
				prem_q  <= '0;
				seg_q   <= '0;
				first_q <= 1'b1;
				trig_q  <= 1'b0;
				k_q     <= 2'd0;
			end
			C_TRIG_INIT: begin
				z_q   <= z_c;
				neg_q <= arg[31];
			end
			C_TRIG_Z2: begin
				z2_q <= prod_q[60:30];
				hr_q <= sine_coef(3'd5);
				h_q  <= 3'd4;
			end
			C_H_WB: begin
				hr_q <= hsub;
				if (!st.h_zero) h_q <= h_q - 3'd1;
			end
			C_F_WB: begin
				if (trig_q) sinv_q <= fval;
				else cosv_q <= fval;
				trig_q <= !trig_q;
			end
			C_P_W: begin
				w_q <= psum[62:30];
			end
			C_P_WB: begin
				end_q[k_q] <= psat;
				k_q        <= k_n;
			end
			C_PT_FIRST: begin
				start_q <= end_q;
				first_q <= 1'b0;
				pq_q    <= pq_n;
				prem_q  <= prem_n;
			end
			default: ;
		endcase
	end

	// Buffer counters and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= '0;
			ic_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == C_CLEAR) begin
				vc_q <= '0;
				ic_q <= '0;
			end else if (cmd == C_EMIT && kept_c) begin
				vc_q <= vc_q + CNT_W'(2);
				ic_q <= ic_q + CNT_W'(2);
			end
			if (cmd == C_EMIT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Status to the controller.
	always_comb begin
		st.kind       = kind_q;
		st.r_pos      = !r_q[31] && (r_q != 32'sd0);
		st.d_zero     = d_q == 5'd0;
		st.k_last     = k_q == 2'd2;
		st.it_zero    = it_q == 5'd0;
		st.dest_t     = dest_t_q;
		st.h_zero     = h_q == 3'd0;
		st.trig_sin   = trig_q;
		st.first      = first_q;
		st.seg_last   = ({1'b0, seg_q} + 5'd1) == d_q;
		st.plane_more = (kind_q == KIND_SPHERE) && (plane_q != 2'd2);
		st.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = {4'd0, o_slot_q, o_color_q, o_end_q[2], o_end_q[1], o_end_q[0],
	                    o_start_q[2], o_start_q[1], o_start_q[0]};
	assign out_kept  = o_kept_q;
	assign out_last  = o_last_q;

endmodule

FILE: sv/wcsg_checker.sv
module wcsg_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [263:0] s_axis_tdata,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [239:0] m_axis_tdata,
	input logic         m_axis_tuser,
	input logic         m_axis_tlast
);

	// No result is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("stalled result changed");

	// A dropped segment reports slot zero.
	a_drop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[235:224] == 12'd0)
		else $error("dropped segment with nonzero slot");

	// The block is busy in the cycle after a request is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken twice in a row");

endmodule

bind wire_circle_segment_generator wcsg_checker u_wcsg_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import wcsg_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	// One request as the generator sees it.
	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] cx, cy, cz, rad, nx, ny, nz;
		logic [31:0]        color;
		logic [4:0]         count;
	} circle_req_t;

	// One line segment as it should leave the generator.
	typedef struct {
		logic [31:0] pt[6];
		logic [31:0] color;
		logic [11:0] slot;
		logic        kept;
		logic        last;
	} segment_t;

	// Tracks the vertex and index counters and holds the segments still owed.
	class segment_scoreboard;
		segment_t    pending_segments[$];
		longint      vertex_used, index_used;
		int          mismatches, requests_seen, segments_seen, dropped_seen;
		longint unsigned taylor[6] = '{64'd1686629713, 64'd693598668, 64'd85569306,
			64'd5026994, 64'd172272, 64'd3864};

		function void clear_frame();
			vertex_used = 0;
			index_used  = 0;
		endfunction

		// Quarter-wave sine in Q30 by Horner steps on the Taylor series.
		function longint unsigned quarter_sine(longint unsigned z);
			longint unsigned z2, r;
			z2 = (z * z) >> 30;
			r  = taylor[5];
			for (int k = 4; k >= 0; k--) r = taylor[k] - ((z2 * r) >> 30);
			r = (z * r) >> 30;
			return (r > 64'd1073741824) ? 64'd1073741824 : r;
		endfunction

		function longint turn_sine(logic [31:0] ph);
			longint unsigned mag;
			mag = ph[30] ? quarter_sine(64'd1073741824 - ph[29:0]) : quarter_sine(ph[29:0]);
			return ph[31] ? -longint'(mag) : longint'(mag);
		endfunction

		function longint unsigned root_floor(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Unit vector in Q30; a zero vector stays zero.
		function void to_unit(input longint v[3], output longint o[3]);
			longint unsigned mag[3], sum, len;
			sum = 0;
			for (int k = 0; k < 3; k++) begin
				mag[k] = (v[k] < 0) ? longint'(-v[k]) : v[k];
				sum += mag[k] * mag[k];
			end
			len = root_floor(sum);
			for (int k = 0; k < 3; k++) begin
				o[k] = (len != 0) ? longint'((mag[k] << 30) / len) : 0;
				if (v[k] < 0) o[k] = -o[k];
			end
		endfunction

		function logic [31:0] plane_coord(longint tc, longint bc, longint c, longint s,
			longint ctr, longint r);
			longint w, v;
			w = (tc * c + bc * s) >>> 30;
			v = ctr + ((w * r) >>> 30);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			return v[31:0];
		endfunction

		// Queues the segments of one circle and claims buffer slots for them.
		function void add_circle(longint t[3], longint b[3], longint ctr[3], longint r,
			int d, logic [31:0] color);
			segment_t    seg;
			logic [31:0] ph[2];
			longint      c[2], s[2];
			for (int i = 0; i < d; i++) begin
				ph[0] = 32'((longint'(i) << 32) / d);
				ph[1] = 32'((longint'(i + 1) << 32) / d);
				for (int e = 0; e < 2; e++) begin
					c[e] = turn_sine(ph[e] + 32'h4000_0000);
					s[e] = turn_sine(ph[e]);
				end
				for (int k = 0; k < 3; k++) begin
					seg.pt[k]     = plane_coord(t[k], b[k], c[0], s[0], ctr[k], r);
					seg.pt[3 + k] = plane_coord(t[k], b[k], c[1], s[1], ctr[k], r);
				end
				seg.color = color;
				seg.last  = 1'b0;
				if (vertex_used + 2 >= MAX_VERTICES || index_used + 2 >= MAX_INDICES) begin
					seg.slot = '0;
					seg.kept = 1'b0;
				end else begin
					seg.slot = vertex_used[11:0];
					seg.kept = 1'b1;
					vertex_used += 2;
					index_used  += 2;
				end
				pending_segments.push_back(seg);
			end
		endfunction

		// Works out the segments that one accepted request must produce.
		function void note_request(circle_req_t req);
			longint ctr[3], r, t[3], b[3], raw[3], n[3], cr[3];
			int     d, before_len;
			requests_seen++;
			before_len = pending_segments.size();
			if (req.kind == KIND_BEGIN) begin
				clear_frame();
				return;
			end
			if (req.kind != KIND_CIRCLE && req.kind != KIND_SPHERE) return;
			d = req.count;
			if (d > D_CAP) d = D_CAP;
			ctr = '{req.cx, req.cy, req.cz};
			r   = req.rad;
			if (req.kind == KIND_CIRCLE) begin
				if (r <= 0) return;
				raw = '{req.nx, req.ny, req.nz};
				to_unit(raw, n);
				// Near the poles the tangent is built from the X axis instead of Y.
				if (((n[1] < 0) ? -n[1] : n[1]) < NEAR_POLE_Q30) cr = '{-n[2], 0, n[0]};
				else cr = '{0, n[2], -n[1]};
				to_unit(cr, t);
				b[0] = (n[1] * t[2] - n[2] * t[1]) >>> 30;
				b[1] = (n[2] * t[0] - n[0] * t[2]) >>> 30;
				b[2] = (n[0] * t[1] - n[1] * t[0]) >>> 30;
				add_circle(t, b, ctr, r, d, req.color);
			end else begin
				for (int p = 0; p < 3; p++) begin
					for (int k = 0; k < 3; k++) begin
						t[k] = (k == p) ? ONE_Q30 : 0;
						b[k] = (k == (p + 1) % 3) ? ONE_Q30 : 0;
					end
					add_circle(t, b, ctr, r, d, req.color);
				end
			end
			if (pending_segments.size() > before_len)
				pending_segments[pending_segments.size() - 1].last = 1'b1;
		endfunction

		function void report(string what, longint unsigned want, longint unsigned got);
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on segment %0d, %s: expected %h, got %h",
					segments_seen, what, want, got);
		endfunction

		// Compares one segment from the output with the oldest one owed.
		function void check_segment(logic [239:0] data, logic kept, logic last);
			segment_t want;
			string    names[6] = '{"start_x", "start_y", "start_z", "end_x", "end_y", "end_z"};
			segments_seen++;
			if (!kept) dropped_seen++;
			if (pending_segments.size() == 0) begin
				report("unexpected segment", 0, data[63:0]);
				return;
			end
			want = pending_segments.pop_front();
			for (int k = 0; k < 6; k++)
				if (data[32*k +: 32] !== want.pt[k]) report(names[k], want.pt[k], data[32*k +: 32]);
			if (data[223:192] !== want.color) report("segment_color", want.color, data[223:192]);
			if (data[235:224] !== want.slot) report("vertex_slot", want.slot, data[235:224]);
			if (data[239:236] !== 4'd0) report("tdata fill", 0, data[239:236]);
			if (kept !== want.kept) report("kept", want.kept, kept);
			if (last !== want.last) report("last_segment", want.last, last);
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [263:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [239:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	segment_scoreboard board;
	int burst_left;
	int ready_left = 0;
	int idle_cycles = 0;

	wire_circle_segment_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic circle_req_t make_req(logic [1:0] kind, logic [31:0] cx, logic [31:0] cy,
		logic [31:0] cz, logic [31:0] rad, logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
		logic [31:0] color, int count);
		circle_req_t req;
		req.kind  = kind;
		req.cx    = cx;
		req.cy    = cy;
		req.cz    = cz;
		req.rad   = rad;
		req.nx    = nx;
		req.ny    = ny;
		req.nz    = nz;
		req.color = color;
		req.count = 5'(count);
		return req;
	endfunction

	// Q16.16 value: mostly modest, sometimes full range, zero or an extreme.
	function automatic logic [31:0] rand_fixed();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			2, 3:    return $urandom;
			default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h00ff_ffff)
				: -$urandom_range(0, 32'h00ff_ffff);
		endcase
	endfunction

	function automatic circle_req_t rand_req();
		circle_req_t req;
		int pick;
		pick = $urandom_range(0, 99);
		req = make_req((pick < 4) ? KIND_BEGIN : (pick < 52) ? KIND_CIRCLE
			: (pick < 92) ? KIND_SPHERE : 2'd3,
			rand_fixed(), rand_fixed(), rand_fixed(), '0, rand_fixed(), rand_fixed(),
			rand_fixed(), $urandom, 0);
		// Radius positive in most circles so that the segment path gets exercised.
		case ($urandom_range(0, 9))
			0:       req.rad = $urandom;
			1:       req.rad = -$urandom_range(0, 32'h00ff_ffff);
			2:       req.rad = '0;
			default: req.rad = $urandom_range(1, 32'h00ff_ffff);
		endcase
		// Near-pole normals now and then.
		if ($urandom_range(0, 5) == 0) req.ny = $urandom_range(0, 1) ? 32'h0010_0000 : 32'hfff0_0000;
		case ($urandom_range(0, 9))
			0:       req.count = 5'($urandom);
			1:       req.count = 5'd16;
			default: req.count = 5'($urandom_range(1, 6));
		endcase
		return req;
	endfunction

	// Offers one request, then holds it until the generator takes it.
	task automatic send_req(circle_req_t req);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req.kind;
		s_axis_tdata  <= {3'd0, req.count, req.color, req.nz, req.ny, req.nx, req.rad, req.cz,
			req.cy, req.cx};
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(req);
		burst_left--;
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = $urandom_range(1, 6);
		end
	endtask

	// Receiver: runs of readiness and stalls of random length.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_segment(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		if (ready_left <= 0) begin
			if ($urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				ready_left = $urandom_range(1, 12);
			end else begin
				m_axis_tready <= 1'b1;
				ready_left = $urandom_range(1, 60);
			end
		end else begin
			ready_left--;
		end
	end

	// Watchdog on cycles with no request and no segment accepted.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		circle_req_t req;
		board = new();
		board.clear_frame();
		burst_left    = 3;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = KIND_BEGIN;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: basis cases, extremes and the special cases.
		send_req(make_req(KIND_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
			32'hdead_beef, 4));
		send_req(make_req(KIND_CIRCLE, 32'h0002_0000, 32'hffff_0000, 0, 32'h0003_0000, 0,
			32'h0001_0000, 0, 32'h1234_5678, 6));
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 32'h0001_0000, 32'h0000_1999,
			32'h0001_0000, 0, 0, 5));
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'hffff_ffff, 3));
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 4));
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 32'h8000_0000, 0, 0, 32'h0001_0000, 0, 4));
		send_req(make_req(KIND_CIRCLE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'haaaa_5555, 16));
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0));
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 31));
		send_req(make_req(KIND_SPHERE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0002_0000, 0, 0, 0, 32'h5555_aaaa, 1));
		send_req(make_req(KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 2));
		send_req(make_req(KIND_SPHERE, 0, 0, 0, 32'hfffe_0000, 0, 0, 0, 0, 3));
		send_req(make_req(KIND_SPHERE, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0, 0, 0,
			0, 16));
		send_req(make_req(2'd3, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 4));
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 32'h0000_0001, 32'h8000_0000, 0, 0, 0, 7));

		// Fill the vertex buffer past capacity so that segments get dropped.
		send_req(make_req(KIND_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 44; i++) begin
			req = rand_req();
			req.kind  = KIND_SPHERE;
			req.count = 5'd16;
			send_req(req);
		end
		send_req(make_req(KIND_CIRCLE, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 4));

		// Random part.
		for (int i = 0; i < 58; i++) send_req(rand_req());
		s_axis_tvalid <= 1'b0;

		while (board.pending_segments.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Ran %0d requests and checked %0d segments, %0d of them dropped as buffers filled.",
			board.requests_seen, board.segments_seen, board.dropped_seen);
		if (board.mismatches == 0 && board.pending_segments.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d segments missing", board.mismatches,
				board.pending_segments.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/wcsg_pkg.sv
sv/wcsg_ctrl.sv
sv/wcsg_datapath.sv
sv/wire_circle_segment_generator.sv
sv/wcsg_checker.sv
test/tb_top.sv
